// ----- hdl/fcce_pkg.sv -----
// shared types and constants for the fat32 cluster chain engine
// no dependencies
package fcce_pkg;

  localparam int unsigned AddrW  = 12;
  localparam int unsigned EntryW = 28;
  localparam int unsigned LimW   = 13;

  localparam logic [2:0] CMD_GET   = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_NEXT  = 3'd2;
  localparam logic [2:0] CMD_ALLOC = 3'd3;
  localparam logic [2:0] CMD_FREE  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd0;
  localparam logic [1:0] REG_DATA_START    = 2'd1;
  localparam logic [1:0] REG_SECT_PER_CLUS = 2'd2;
  localparam logic [1:0] REG_WRITE_PROTECT = 2'd3;

  localparam logic [EntryW-1:0] END_OF_CHAIN = 28'hFFFFFF8;
  localparam logic [EntryW-1:0] EOC_MARK     = 28'hFFFFFFF;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
    logic [AddrW-1:0]  raddr;
  } tbl_req_t;

endpackage

// ----- hdl/fcce_table.sv -----
// allocation table memory with a clearing pass after reset
// depends on fcce_pkg
module fcce_table #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fcce_pkg::tbl_req_t       req_i,
  output logic [fcce_pkg::EntryW-1:0] rdata_o,
  output logic                     busy_o
);
  import fcce_pkg::*;

  localparam int unsigned MemAw = $clog2(DEPTH);
  localparam logic [MemAw-1:0] LastIdx = MemAw'(DEPTH - 1);

  logic [EntryW-1:0] mem [DEPTH];
  logic [MemAw-1:0]  clr_cnt_q, clr_cnt_d;
  logic              busy_q, busy_d;
  logic [EntryW-1:0] rdata_q;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + MemAw'(1);
      if (clr_cnt_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (req_i.we) begin
      mem[req_i.waddr[MemAw-1:0]] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr[MemAw-1:0]];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// ----- hdl/fat32_cluster_chain_engine_core.sv -----
// fat32 cluster chain engine top level: command sequencer, config registers, result stage
// depends on fcce_pkg and fcce_table
//
// usage:
//   commands arrive on the s_axis channel, one result per command leaves on m_axis.
//   the config port writes cluster_count, data_area_start, sectors_per_cluster and
//   write_protect by index 0 to 3; write it only while the engine is idle.
//   after reset the table is swept to free, one entry a cycle over all min(TABLE_ENTRIES,
//   4096) entries; s_axis_tready stays low during the sweep.
//   one command is in work at a time, all table traffic goes through one memory port.
//   sequencing: set, unknown and rejected commands go from decode straight to the result
//   step; get and next read the entry first; alloc scans entries from the hint and, on a
//   free one, adds a sector step; free chain checks and then reads each link, and stops
//   in the check at an invalid or protected cluster or the guard.
//   s_axis_tready returns in the same cycle that the result is loaded into the output
//   register.
//   a finished result sits in an output register; the next command may be accepted
//   while it waits, and a stalled receiver only holds the sequencer in its last step.
//   the free-chain walk stops with status 1 after the valid cluster count plus one links.
module fat32_cluster_chain_engine_core #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // command[2:0], cluster[30:3], new_value[58:31]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // status[1:0], result_value[29:2], first_sector[61:30]
);
  import fcce_pkg::*;

  localparam int unsigned MemDepth = (TABLE_ENTRIES < 4096) ? TABLE_ENTRIES : 4096;
  localparam logic [LimW-1:0] DepthL = LimW'(MemDepth);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_ENTRY  = 8'b0000_0100,
    S_ASCAN  = 8'b0000_1000,
    S_SECT   = 8'b0001_0000,
    S_FCHECK = 8'b0010_0000,
    S_FREAD  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [11:0] cluster_count_q;
  logic [31:0] data_start_q;
  logic [7:0]  spc_q;
  logic        wp_q;

  logic [AddrW-1:0]  hint_q, hint_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [EntryW-1:0] clus_q, clus_d;
  logic [EntryW-1:0] nv_q, nv_d;
  logic [EntryW-1:0] cur_q, cur_d;
  logic [LimW-1:0]   n_q, n_d;
  logic [LimW-1:0]   guard_q, guard_d;
  logic [19:0]       prod_q, prod_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [EntryW-1:0] res_value_q, res_value_d;
  logic [31:0]       res_sec_q, res_sec_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [EntryW-1:0] out_value_q, out_value_d;
  logic [31:0]       out_sec_q, out_sec_d;

  tbl_req_t          tbl_req;
  logic [EntryW-1:0] tbl_rdata;
  logic              tbl_busy;

  logic [LimW-1:0]   lim_raw, lim, count;
  logic [EntryW-1:0] chk_val;
  logic              chk_ok;
  logic              hint_ok;
  logic [LimW-1:0]   cur_inc;
  logic [LimW-1:0]   cur_wrap;
  logic              in_acc;
  logic              out_free;

  assign lim_raw = {1'b0, cluster_count_q} + LimW'(2);
  assign lim     = (lim_raw > DepthL) ? DepthL : lim_raw;
  assign count   = (lim > LimW'(2)) ? lim - LimW'(2) : '0;

  // shared range check against the volume limit
  assign chk_ok  = (chk_val >= EntryW'(2)) && (chk_val < {{(EntryW-LimW){1'b0}}, lim});
  assign hint_ok = (hint_q >= AddrW'(2)) && ({1'b0, hint_q} < lim);

  assign cur_inc  = cur_q[LimW-1:0] + LimW'(1);
  assign cur_wrap = (cur_inc >= lim) ? LimW'(2) : cur_inc;

  assign s_axis_tready = (state_q == S_IDLE) && !tbl_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    unique case (state_q)
      S_ENTRY: chk_val = tbl_rdata;
      S_FCHECK: chk_val = cur_q;
      default: chk_val = clus_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    hint_d       = hint_q;
    cmd_d        = cmd_q;
    clus_d       = clus_q;
    nv_d         = nv_q;
    cur_d        = cur_q;
    n_d          = n_q;
    guard_d      = guard_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_sec_d    = res_sec_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_sec_d    = out_sec_q;
    tbl_req.we    = 1'b0;
    tbl_req.waddr = cur_q[AddrW-1:0];
    tbl_req.wdata = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = s_axis_tdata[2:0];
          clus_d  = s_axis_tdata[30:3];
          nv_d    = s_axis_tdata[58:31];
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_d = ST_INVALID;
        res_value_d  = '0;
        res_sec_d    = '0;
        state_d      = S_DONE;
        case (cmd_q)
          CMD_GET, CMD_NEXT: begin
            if (chk_ok) begin
              cur_d   = clus_q;
              state_d = S_ENTRY;
            end
          end
          CMD_SET: begin
            if (chk_ok && !wp_q) begin
              tbl_req.we    = 1'b1;
              tbl_req.waddr = clus_q[AddrW-1:0];
              tbl_req.wdata = nv_q;
              res_status_d  = ST_OK;
            end
          end
          CMD_ALLOC: begin
            res_status_d = ST_NOSPACE;
            if (!wp_q && count != '0) begin
              cur_d   = hint_ok ? {{(EntryW-AddrW){1'b0}}, hint_q} : EntryW'(2);
              n_d     = '0;
              state_d = S_ASCAN;
            end
          end
          CMD_FREE: begin
            res_status_d = ST_OK;
            if (clus_q != '0) begin
              cur_d   = clus_q;
              guard_d = '0;
              state_d = S_FCHECK;
            end
          end
          default: begin
          end
        endcase
      end
      S_ENTRY: begin
        res_status_d = ST_OK;
        state_d      = S_DONE;
        if (cmd_q == CMD_GET) begin
          res_value_d = tbl_rdata;
        end else if (tbl_rdata >= END_OF_CHAIN) begin
          res_value_d = '0;
        end else if (chk_ok) begin
          res_value_d = tbl_rdata;
        end else begin
          res_status_d = ST_INVALID;
        end
      end
      S_ASCAN: begin
        if (tbl_rdata == '0) begin
          tbl_req.we    = 1'b1;
          tbl_req.wdata = EOC_MARK;
          hint_d        = (cur_inc >= lim) ? AddrW'(2) : cur_inc[AddrW-1:0];
          res_status_d  = ST_OK;
          res_value_d   = cur_q;
          prod_d        = 20'(cur_q[AddrW-1:0] - AddrW'(2)) * 20'(spc_q);
          state_d       = S_SECT;
        end else if (n_q + LimW'(1) == count) begin
          state_d = S_DONE;
        end else begin
          n_d   = n_q + LimW'(1);
          cur_d = {{(EntryW-LimW){1'b0}}, cur_wrap};
        end
      end
      S_SECT: begin
        res_sec_d = data_start_q + {12'b0, prod_q};
        state_d   = S_DONE;
      end
      S_FCHECK: begin
        if (guard_q > count) begin
          res_status_d = ST_INVALID;
          state_d      = S_DONE;
        end else if (!chk_ok) begin
          state_d = S_DONE;
        end else if (wp_q) begin
          res_status_d = ST_INVALID;
          state_d      = S_DONE;
        end else begin
          state_d = S_FREAD;
        end
      end
      S_FREAD: begin
        tbl_req.we    = 1'b1;
        tbl_req.wdata = '0;
        if (cur_q[LimW-1:0] < {1'b0, hint_q}) begin
          hint_d = cur_q[AddrW-1:0];
        end
        if (tbl_rdata >= END_OF_CHAIN || tbl_rdata < EntryW'(2)) begin
          state_d = S_DONE;
        end else begin
          cur_d   = tbl_rdata;
          guard_d = guard_q + LimW'(1);
          state_d = S_FCHECK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_sec_d    = res_sec_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    tbl_req.raddr = cur_d[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      hint_q          <= AddrW'(2);
      out_valid_q     <= 1'b0;
      cluster_count_q <= 12'd4094;
      data_start_q    <= '0;
      spc_q           <= 8'd1;
      wp_q            <= 1'b0;
    end else begin
      state_q     <= state_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CLUSTER_COUNT: cluster_count_q <= cfg_data_i[11:0];
          REG_DATA_START:    data_start_q    <= cfg_data_i;
          REG_SECT_PER_CLUS: spc_q           <= cfg_data_i[7:0];
          REG_WRITE_PROTECT: wp_q            <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    clus_q       <= clus_d;
    nv_q         <= nv_d;
    cur_q        <= cur_d;
    n_q          <= n_d;
    guard_q      <= guard_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_sec_q    <= res_sec_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_sec_q    <= out_sec_d;
  end

  fcce_table #(
    .DEPTH(MemDepth)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata),
    .busy_o  (tbl_busy)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_sec_q, out_value_q, out_status_q};

endmodule
